[rtl/core/ezrp_pkg.sv]
// ezrp_pkg: shared constants, codes and types of the edge zone record parser
// used by every module under rtl/core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ezrp_pkg;

   localparam int ELEVATIONS  = 3;
   localparam int ELEV_W      = 4;
   localparam int WORD_W      = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int RSP_DATA_W  = 144;

   localparam logic [WORD_W-1:0] MAGIC_RESET = 32'h4544_4745;

   // register index, taken from paddr[2]
   localparam logic REG_MAGIC = 1'b0;

   localparam logic [1:0] KIND_ZONE   = 2'd0;
   localparam logic [1:0] KIND_SQUARE = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_BAD_MAGIC    = 3'd1;
   localparam logic [2:0] STATUS_BAD_VERSION  = 3'd2;
   localparam logic [2:0] STATUS_RESERVED     = 3'd3;
   localparam logic [2:0] STATUS_SHORT_HEADER = 3'd4;
   localparam logic [2:0] STATUS_SHORT_SQUARE = 3'd5;
   localparam logic [2:0] STATUS_SHORT_ZONE   = 3'd6;
   localparam logic [2:0] STATUS_SHORT_IND    = 3'd7;

   localparam logic [1:0] VERSION_NONE = 2'd0;
   localparam logic [1:0] VERSION_ONE  = 2'd1;
   localparam logic [1:0] VERSION_TWO  = 2'd2;

   // classified word as it travels from front to back
   typedef struct packed {
      logic              is_end;
      logic [WORD_W-1:0] word;
      logic              is_magic;
      logic              is_v1;
      logic              is_v2;
      logic              is_zero;
      logic [3:0]        clip;
   } entry_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ELEV_W-1:0] elevation;
      logic [WORD_W-1:0] rect_left;
      logic [WORD_W-1:0] rect_top;
      logic [WORD_W-1:0] rect_right;
      logic [WORD_W-1:0] rect_bottom;
      logic [3:0]        clip_sides;
      logic [1:0]        file_version;
      logic [2:0]        status;
   } record_type;

endpackage

`default_nettype wire

[rtl/core/ezrp_front.sv]
// ezrp_front: classifies each incoming word (magic, version, zero, clip bits)
// depends on ezrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ezrp_front import ezrp_pkg::*; (
   input  wire logic              command,
   input  wire logic [WORD_W-1:0] word,
   input  wire logic [WORD_W-1:0] magic,
   output entry_type              entry
);

   always_comb begin
      entry.is_end   = command;
      entry.word     = word;
      entry.is_magic = (word == magic);
      entry.is_v1    = (word == 32'd1);
      entry.is_v2    = (word == 32'd2);
      entry.is_zero  = (word == 32'd0);
      entry.clip     = {word[24], word[16], word[8], word[0]};
   end

endmodule

`default_nettype wire

[rtl/core/ezrp_queue.sv]
// ezrp_queue: short flip-flop queue between front and back
// depends on ezrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ezrp_queue import ezrp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  push_entry,
   output logic            push_ready,
   input  wire logic       pop,
   output entry_type       head_entry,
   output logic            head_valid
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/core/ezrp_back.sv]
// ezrp_back: parse state machine over classified words and the result register
// depends on ezrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ezrp_back import ezrp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  wire entry_type  head_entry,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output record_type      rsp_record
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_SQUARE = 3'd1;
   localparam logic [2:0] PH_ZONE   = 3'd2;
   localparam logic [2:0] PH_IND    = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   localparam logic [ELEV_W-1:0] LAST_ELEV = ELEV_W'(ELEVATIONS - 1);

   typedef struct packed {
      logic [2:0]        phase;
      logic [ELEV_W-1:0] elev;
   } enter_type;

   logic [2:0]        phase_ff, phase_in;
   logic [2:0]        pos_ff, pos_in;
   logic [ELEV_W-1:0] elev_ff, elev_in;
   logic [WORD_W-1:0] ind_ff, ind_in;
   logic              v2_ff, v2_in;
   logic              fin_ff, fin_in;
   logic [WORD_W-1:0] rect_ff [4];
   logic [WORD_W-1:0] rect_in [4];
   logic              rsp_valid_ff, rsp_valid_in;
   record_type        rsp_rec_ff, rsp_rec_in;
   record_type        rec;
   logic              emit;
   logic              elev_match;
   logic              ind_match;
   logic [ELEV_W:0]   next_start;
   entry_type         e;
   enter_type         ent;

   // first elevation at or after start that is walked
   function automatic enter_type enter_fn(input logic [ELEV_W:0] start, input logic v2,
                                          input logic [WORD_W-1:0] ind);
      enter_type r;
      r.phase = PH_DONE;
      r.elev  = LAST_ELEV;
      if (v2) begin
         if (start < (ELEV_W+1)'(ELEVATIONS)) begin
            r.phase = PH_SQUARE;
            r.elev  = start[ELEV_W-1:0];
         end
      end else if (ind < WORD_W'(ELEVATIONS) && ind >= WORD_W'(start)) begin
         r.phase = PH_ZONE;
         r.elev  = ind[ELEV_W-1:0];
      end
      return r;
   endfunction

   assign e          = head_entry;
   assign pop        = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_record = rsp_rec_ff;
   assign next_start = {1'b0, elev_ff} + 1'b1;
   assign elev_match = (ind_ff == WORD_W'(elev_ff));
   assign ind_match  = (e.word == WORD_W'(elev_ff));

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      elev_in  = elev_ff;
      ind_in   = ind_ff;
      v2_in    = v2_ff;
      fin_in   = fin_ff;
      rect_in  = rect_ff;
      emit     = 1'b0;
      ent      = enter_fn('0, v2_ff, ind_ff);

      rec.kind         = KIND_END;
      rec.elevation    = elev_ff;
      rec.rect_left    = '0;
      rec.rect_top     = '0;
      rec.rect_right   = '0;
      rec.rect_bottom  = '0;
      rec.clip_sides   = '0;
      rec.file_version = (phase_ff == PH_HEADER) ? VERSION_NONE :
                         (v2_ff ? VERSION_TWO : VERSION_ONE);
      rec.status       = STATUS_OK;

      if (pop && !fin_ff) begin
         if (e.is_end) begin
            emit   = 1'b1;
            fin_in = 1'b1;
            unique case (phase_ff)
               PH_HEADER: rec.status = STATUS_SHORT_HEADER;
               PH_SQUARE: rec.status = STATUS_SHORT_SQUARE;
               PH_ZONE:   rec.status = (elev_ff == LAST_ELEV) ? STATUS_OK : STATUS_SHORT_ZONE;
               PH_IND:    rec.status = (elev_ff == LAST_ELEV) ? STATUS_OK : STATUS_SHORT_IND;
               default:   rec.status = STATUS_OK;
            endcase
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (pos_ff == 3'd0) begin
                     if (!e.is_magic) begin
                        emit       = 1'b1;
                        fin_in     = 1'b1;
                        rec.status = STATUS_BAD_MAGIC;
                     end else begin
                        pos_in = 3'd1;
                     end
                  end else if (pos_ff == 3'd1) begin
                     if (!(e.is_v1 || e.is_v2)) begin
                        emit       = 1'b1;
                        fin_in     = 1'b1;
                        rec.status = STATUS_BAD_VERSION;
                     end else begin
                        v2_in  = e.is_v2;
                        pos_in = 3'd2;
                     end
                  end else begin
                     if (!e.is_zero) begin
                        emit       = 1'b1;
                        fin_in     = 1'b1;
                        rec.status = STATUS_RESERVED;
                     end else begin
                        ent      = enter_fn('0, v2_ff, ind_ff);
                        phase_in = ent.phase;
                        elev_in  = ent.elev;
                        pos_in   = '0;
                     end
                  end
               end
               PH_SQUARE: begin
                  if (pos_ff < 3'd4) begin
                     rect_in[pos_ff[1:0]] = e.word;
                     pos_in               = pos_ff + 1'b1;
                  end else begin
                     emit            = 1'b1;
                     rec.kind        = KIND_SQUARE;
                     rec.rect_left   = rect_ff[0];
                     rec.rect_top    = rect_ff[1];
                     rec.rect_right  = rect_ff[2];
                     rec.rect_bottom = rect_ff[3];
                     rec.clip_sides  = e.clip;
                     pos_in          = '0;
                     if (elev_match) begin
                        phase_in = PH_ZONE;
                     end else begin
                        ent      = enter_fn(next_start, v2_ff, ind_ff);
                        phase_in = ent.phase;
                        elev_in  = ent.elev;
                     end
                  end
               end
               PH_ZONE: begin
                  rect_in[pos_ff[1:0]] = e.word;
                  if (pos_ff < 3'd3) begin
                     pos_in = pos_ff + 1'b1;
                  end else begin
                     emit            = 1'b1;
                     rec.kind        = KIND_ZONE;
                     rec.rect_left   = rect_ff[0];
                     rec.rect_top    = rect_ff[1];
                     rec.rect_right  = rect_ff[2];
                     rec.rect_bottom = e.word;
                     phase_in        = PH_IND;
                     pos_in          = '0;
                  end
               end
               PH_IND: begin
                  ind_in = e.word;
                  pos_in = '0;
                  if (ind_match) begin
                     phase_in = PH_ZONE;
                  end else begin
                     ent      = enter_fn(next_start, v2_ff, e.word);
                     phase_in = ent.phase;
                     elev_in  = ent.elev;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      rsp_rec_in = rsp_rec_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_rec_in   = rec;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         elev_ff      <= '0;
         ind_ff       <= '0;
         v2_ff        <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         elev_ff      <= elev_in;
         ind_ff       <= ind_in;
         v2_ff        <= v2_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rect_ff    <= rect_in;
      rsp_rec_ff <= rsp_rec_in;
   end

endmodule

`default_nettype wire

[rtl/core/edge_zone_record_parser.sv]
// edge_zone_record_parser: top level; magic register, front classifier,
// queue and back parser; depends on ezrp_pkg, ezrp_front, ezrp_queue, ezrp_back
//
// usage:
//   req channel: one 32-bit file word per transfer in req_tdata, req_tuser high
//     marks end of stream (word ignored); words are big-endian file words
//   rsp channel: one record per transfer; rsp_tuser is the kind (zone, square,
//     end); the end record carries the status and closes the parse
//   csr port: magic word register at byte address 0, written in the access
//     cycle of a write, readable at any time; pready is tied high
//   path: the word that completes a record is written into the queue, and the
//     record is then held in the output register that drives rsp_tvalid
//   throughput: one word per cycle, set by the parse step in the back end, as
//     long as no record waits on a low rsp_tready; while one waits the
//     four-entry queue fills up to its four entries, then req_tready drops
//   reset: synchronous; clears the queue, the output register and the parse
//     state, and loads the magic register with ASCII EDGE
//   after the end record every word is taken and dropped until reset
`timescale 1ns / 1ps
`default_nettype none

module edge_zone_record_parser import ezrp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: word[31:0]
   input  wire logic [WORD_W-1:0]     req_tdata,
   // req_tuser: command[0]
   input  wire logic                  req_tuser,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // rsp_tdata: elevation[3:0], rect_left[35:4], rect_top[67:36],
   // rect_right[99:68], rect_bottom[131:100], clip_sides[135:132],
   // file_version[137:136], status[140:138], zero fill[143:141]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: kind[1:0]
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [WORD_W-1:0] magic_ff, magic_in;
   entry_type         front_entry;
   entry_type         head_entry;
   logic              head_valid;
   logic              pop;
   record_type        rec;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MAGIC) ? magic_ff : 32'd0;

   always_comb begin
      magic_in = magic_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr[2] == REG_MAGIC) begin
         magic_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= MAGIC_RESET;
      end else begin
         magic_ff <= magic_in;
      end
   end

   ezrp_front u_front (
      .command (req_tuser),
      .word    (req_tdata),
      .magic   (magic_ff),
      .entry   (front_entry)
   );

   ezrp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_entry (front_entry),
      .push_ready (req_tready),
      .pop        (pop),
      .head_entry (head_entry),
      .head_valid (head_valid)
   );

   ezrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_record (rec)
   );

   assign rsp_tuser = rec.kind;
   assign rsp_tdata = {3'b000, rec.status, rec.file_version, rec.clip_sides,
                       rec.rect_bottom, rec.rect_right, rec.rect_top, rec.rect_left,
                       rec.elevation};

endmodule

`default_nettype wire

[rtl/core/ezrp_checker.sv]
// ezrp_checker: port-level assertions on the parser's result channel
// depends on ezrp_pkg; bound to edge_zone_record_parser below
`timescale 1ns / 1ps
`default_nettype none

module ezrp_checker import ezrp_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [1:0]            rsp_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready
);

   // nothing follows the end record
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == KIND_END |=> !rsp_tvalid)
      else $error("record after end record");

   // rect records only come with status ok and a known version
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_END |->
         rsp_tdata[140:138] == STATUS_OK && rsp_tdata[137:136] != VERSION_NONE)
      else $error("rect record with bad status or version");

   // header failures carry no version
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END &&
      (rsp_tdata[140:138] == STATUS_BAD_MAGIC || rsp_tdata[140:138] == STATUS_BAD_VERSION ||
       rsp_tdata[140:138] == STATUS_RESERVED || rsp_tdata[140:138] == STATUS_SHORT_HEADER)
      |-> rsp_tdata[137:136] == VERSION_NONE)
      else $error("header failure with version set");

   // a stalled transfer holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp transfer changed");

endmodule

bind edge_zone_record_parser ezrp_checker u_ezrp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
